// ----- rtl/rsk_pkg.sv -----
// Package for the record sorter: field widths, the control word that the
// top level broadcasts to the sorting cells, and the controller state type.
// No dependencies.
package rsk_pkg;

  // Widths of the fields on the stream ports.
  localparam int unsigned ScoreW = 16;
  localparam int unsigned TagW   = 32;
  localparam int unsigned DataW  = ScoreW + TagW;

  // Per-cycle command shared by every cell in the chain.
  typedef struct packed {
    logic insert;  // place the incoming record into the sorted chain
    logic shift;   // move every record one cell toward the output
  } rsk_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } rsk_state_e;

endpackage

// ----- rtl/rsk_cell.sv -----
// One cell of the insertion chain: holds a single record and decides each
// cycle whether to keep it, take the incoming record or take a neighbor's.
// Depends on rsk_pkg.
module rsk_cell import rsk_pkg::*; #(
  parameter int unsigned KEY_WIDTH = 16,
  parameter int unsigned TAG_WIDTH = 32,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  rsk_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [KEY_WIDTH-1:0] new_key_i,
  input  logic [TAG_WIDTH-1:0] new_tag_i,
  input  logic                 prev_keep_i,
  input  logic [KEY_WIDTH-1:0] prev_key_i,
  input  logic [TAG_WIDTH-1:0] prev_tag_i,
  input  logic [KEY_WIDTH-1:0] next_key_i,
  input  logic [TAG_WIDTH-1:0] next_tag_i,
  output logic                 keep_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic [TAG_WIDTH-1:0] tag_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [TAG_WIDTH-1:0] tag_q, tag_d;
  logic                 occupied;

  // Occupied cells form a prefix of the chain. A record with an equal key
  // stays ahead of the newcomer, which keeps arrival order among equal keys.
  assign occupied = count_i > CNT_W'(IDX);
  assign keep_o   = occupied && (key_q <= new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    priority if (ctrl_i.shift) begin
      key_d = next_key_i;
      tag_d = next_tag_i;
    end else if (ctrl_i.insert && !keep_o) begin
      if (prev_keep_i) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end else begin
        key_d = prev_key_i;
        tag_d = prev_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

// ----- rtl/record_sort_by_key.sv -----
// Record sorter. Records (key, tag) stream in one per cycle while the sorter
// collects and are placed in ascending key order as they load by a chain of
// CAPACITY cells that all compare against the incoming key at once; equal
// keys keep arrival order. The record with tlast closes the batch: the chain
// then shifts toward the output one record per transfer, and s_axis_tready
// stays low until the transfer marked tlast has left. Records beyond CAPACITY
// are dropped and every result of that batch carries tuser high. Depends on
// rsk_pkg and rsk_cell.
module record_sort_by_key import rsk_pkg::*; #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 16,
  parameter int unsigned TAG_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,  // [15:0] score_key, [47:16] record_tag
  input  logic             s_axis_tlast,  // batch_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,  // [15:0] sorted_key, [47:16] sorted_tag
  output logic             m_axis_tlast,  // run_last
  output logic             m_axis_tuser   // overflowed
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  rsk_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             drop_q, drop_d;
  logic             s_fire, m_fire, full;
  rsk_ctrl_t        ctrl;

  logic [KEY_WIDTH-1:0] new_key;
  logic [TAG_WIDTH-1:0] new_tag;
  logic [KEY_WIDTH-1:0] cell_key  [CAPACITY];
  logic [TAG_WIDTH-1:0] cell_tag  [CAPACITY];
  logic                 cell_keep [CAPACITY];

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign full   = count_q == CntW'(CAPACITY);

  assign new_key = KEY_WIDTH'(s_axis_tdata[ScoreW-1:0]);
  assign new_tag = TAG_WIDTH'(s_axis_tdata[DataW-1:ScoreW]);

  assign ctrl.insert = s_fire && !full;
  assign ctrl.shift  = m_fire;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: if (s_fire && s_axis_tlast) state_d = ST_DRAIN;
      ST_DRAIN:   if (m_fire && m_axis_tlast) state_d = ST_COLLECT;
      default:    state_d = ST_COLLECT;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_COLLECT: s_axis_tready = 1'b1;
      ST_DRAIN:   m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (ctrl.insert) count_d = count_q + CntW'(1);
    if (s_fire && full) drop_d = 1'b1;
    if (m_fire) begin
      count_d = count_q - CntW'(1);
      if (m_axis_tlast) drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_keep;
    logic [KEY_WIDTH-1:0] prev_key, next_key;
    logic [TAG_WIDTH-1:0] prev_tag, next_tag;

    if (i == 0) begin : g_head
      // The head has nothing ahead of it, so it acts as if that spot keeps.
      assign prev_keep = 1'b1;
      assign prev_key  = new_key;
      assign prev_tag  = new_tag;
    end else begin : g_body
      assign prev_keep = cell_keep[i-1];
      assign prev_key  = cell_key[i-1];
      assign prev_tag  = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = '0;
      assign next_tag = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_tag = cell_tag[i+1];
    end

    rsk_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .TAG_WIDTH (TAG_WIDTH),
      .CNT_W     (CntW),
      .IDX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_key_i   (new_key),
      .new_tag_i   (new_tag),
      .prev_keep_i (prev_keep),
      .prev_key_i  (prev_key),
      .prev_tag_i  (prev_tag),
      .next_key_i  (next_key),
      .next_tag_i  (next_tag),
      .keep_o      (cell_keep[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  assign m_axis_tdata = {TagW'(cell_tag[0]), ScoreW'(cell_key[0])};
  assign m_axis_tlast = count_q == CntW'(1);
  assign m_axis_tuser = drop_q;

endmodule

// ----- rtl/rsk_checker.sv -----
// Port-level checks for the record sorter, attached to every instance of the
// top level by the bind statement at the end. Depends on rsk_pkg.
module rsk_checker import rsk_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tlast,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // Loading and draining never overlap.
  a_no_load_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while results are pending");

  // The final record of a batch starts the drain in the next cycle.
  a_drain_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
    else $error("batch end did not start the drain");

  // The run ends with the transfer marked last.
  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("results continue after the last transfer");

  // Keys leave in ascending order within a run.
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tdata[ScoreW-1:0] >= $past(m_axis_tdata[ScoreW-1:0])))
    else $error("keys out of order");

endmodule

bind record_sort_by_key rsk_checker u_rsk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/rsk_sort_sb_pkg.sv -----
// Scoreboard for the record sorter testbench: an insertion-order predictor of
// the sorted runs and a queue of the results it still awaits.
// Depends on rsk_pkg for the field widths.
package rsk_sort_sb_pkg;
  import rsk_pkg::*;

  typedef struct packed {
    logic [ScoreW-1:0] key;
    logic [TagW-1:0]   tag;
  } rsk_record_t;

  typedef struct packed {
    rsk_record_t rec;
    logic        last;
    logic        ovf;
  } sorted_result_t;

  class rsk_sort_scoreboard;
    int unsigned    capacity;
    rsk_record_t    held[$];     // current batch, kept in ascending key order
    logic           dropped;
    sorted_result_t awaited[$];
    int unsigned    errors;
    int unsigned    records_seen;
    int unsigned    results_checked;
    int unsigned    batches;
    int unsigned    overflow_batches;

    function new(int unsigned cap);
      capacity         = cap;
      dropped          = 1'b0;
      errors           = 0;
      records_seen     = 0;
      results_checked  = 0;
      batches          = 0;
      overflow_batches = 0;
    endfunction

    // Called for every record transfer on the input side.
    function void note_record(logic [ScoreW-1:0] key, logic [TagW-1:0] tag,
                              logic batch_end);
      int unsigned    pos;
      rsk_record_t    r;
      sorted_result_t o;
      records_seen++;
      if (held.size() < capacity) begin
        // Stop at the first key that is not greater, so equal keys stay in
        // arrival order.
        pos = held.size();
        while (pos > 0 && held[pos-1].key > key) pos--;
        r.key = key;
        r.tag = tag;
        held.insert(pos, r);
      end else begin
        dropped = 1'b1;
      end
      if (batch_end) begin
        foreach (held[i]) begin
          o.rec  = held[i];
          o.last = (i == held.size() - 1);
          o.ovf  = dropped;
          awaited.push_back(o);
        end
        batches++;
        if (dropped) overflow_batches++;
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    // Called for every result transfer on the output side.
    function void check_result(logic [ScoreW-1:0] key, logic [TagW-1:0] tag,
                               logic last, logic ovf);
      sorted_result_t e;
      results_checked++;
      if (awaited.size() == 0) begin
        $error("unexpected result: sorted_key %0h sorted_tag %0h", key, tag);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (key !== e.rec.key) begin
        $error("sorted_key: expected %0h, got %0h", e.rec.key, key);
        errors++;
      end
      if (tag !== e.rec.tag) begin
        $error("sorted_tag: expected %0h, got %0h", e.rec.tag, tag);
        errors++;
      end
      if (last !== e.last) begin
        $error("run_last: expected %0b, got %0b", e.last, last);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflowed: expected %0b, got %0b", e.ovf, ovf);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

// ----- sim/record_sort_by_key_test.sv -----
// Testbench for record_sort_by_key: streams batches of (key, tag) records with
// random gaps and checks every sorted run against the scoreboard predictor.
// Depends on rsk_pkg, rsk_sort_sb_pkg and the record_sort_by_key RTL.
module record_sort_by_key_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsk_pkg::*;
  import rsk_sort_sb_pkg::*;

  localparam int unsigned CAPACITY       = 64;
  localparam int unsigned ITEM_TARGET    = 360;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;   // [15:0] score_key, [47:16] record_tag
  logic             s_axis_tlast;   // batch_end
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;   // [15:0] sorted_key, [47:16] sorted_tag
  logic             m_axis_tlast;   // run_last
  logic             m_axis_tuser;   // overflowed

  rsk_sort_scoreboard sb = new(CAPACITY);

  logic        calm = 1'b0;       // both sides run without gaps while set
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  record_sort_by_key #(.CAPACITY(CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Narrow ranges give plenty of equal keys; the extremes come up often.
  function automatic logic [ScoreW-1:0] draw_key();
    case ($urandom_range(0, 3))
      0: return ScoreW'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return ScoreW'(1);
          default: return {1'b1, {(ScoreW-1){1'b0}}};
        endcase
      end
      default: return ScoreW'($urandom);
    endcase
  endfunction

  function automatic logic [TagW-1:0] draw_tag();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return TagW'($urandom);
    endcase
  endfunction

  task automatic send_record(input logic [ScoreW-1:0] key, input logic [TagW-1:0] tag,
                             input logic batch_end);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, key};
    s_axis_tlast  <= batch_end;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_record(key, tag, batch_end);
  endtask

  task automatic send_batch(input int unsigned n);
    calm = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < n; i++)
      send_record(draw_key(), draw_tag(), i == n - 1);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // going, so the chain drains into a blocked output and the input stalls.
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      gap = idle_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[ScoreW-1:0], m_axis_tdata[DataW-1:ScoreW],
                      m_axis_tlast, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-record batches at both ends of the key and tag ranges.
    send_record('0, '0, 1'b1);
    send_record('1, '1, 1'b1);
    // Equal keys must leave in arrival order.
    send_record(16'd5, 32'd1, 1'b0);
    send_record(16'd5, 32'd2, 1'b0);
    send_record(16'd5, 32'd3, 1'b0);
    send_record(16'd5, 32'd4, 1'b1);
    // Strictly descending arrival: every record goes to the front.
    send_record(16'hffff, 32'h1111_0000, 1'b0);
    send_record(16'h8000, 32'h2222_0000, 1'b0);
    send_record(16'h0100, 32'h3333_0000, 1'b0);
    send_record(16'h0001, 32'h4444_0000, 1'b0);
    send_record(16'h0000, 32'h5555_0000, 1'b1);
    // Interleaved duplicates mixed with the extremes.
    send_record(16'd300, 32'haaaa_aaaa, 1'b0);
    send_record(16'd100, 32'h5555_5555, 1'b0);
    send_record(16'd300, 32'hdead_0001, 1'b0);
    send_record(16'd100, 32'hdead_0002, 1'b0);
    send_record(16'hffff, 32'h0000_0001, 1'b0);
    send_record(16'h0000, 32'h8000_0000, 1'b1);

    // A full batch during the long output hold-off, then one where only the
    // closing record is dropped, then one well past capacity.
    hold_req = 1'b1;
    send_batch(CAPACITY);
    send_batch(CAPACITY + 1);
    send_batch(CAPACITY + 6);

    while (sb.records_seen < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0)
        send_batch($urandom_range(CAPACITY - 4, CAPACITY + 6));
      else
        send_batch($urandom_range(1, 12));
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d records in %0d batches, %0d of them over capacity",
             sb.records_seen, sb.batches, sb.overflow_batches);
    $display("summary: %0d sorted results checked, %0d mismatches",
             sb.results_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
